[hdl/airfoil_table_interpolator_core_assert.svh]
// ----------------------------------------------------------------------------
// airfoil table interpolator assertion macros
// clocked, reset-qualified same-cycle and next-cycle implication checks
// ----------------------------------------------------------------------------
`ifndef AIRFOIL_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define AIRFOIL_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ATI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ati_pkg.sv]
// ----------------------------------------------------------------------------
// ati_pkg
// function and status codes, sequencer states and shared widths
// ----------------------------------------------------------------------------
package ati_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_INTERP = 2'd1;
    localparam logic [1:0] FUNC_BEST   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_INDEX = 2'd2;

    localparam logic [6:0] CFG_RESET   = 7'd3;
    localparam int         MIN_ENTRIES = 3;
    localparam int         ENTRY_W     = 48;
    localparam logic [4:0] DIV_STEPS   = 5'd16;

    typedef logic signed [16:0] mul_op_t;
    typedef logic signed [33:0] prod_t;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_I_FIRST = 16'h0002,
        ST_I_LAST  = 16'h0004,
        ST_I_SRCH  = 16'h0008,
        ST_I_PROBE = 16'h0010,
        ST_I_RLO   = 16'h0020,
        ST_I_RHI   = 16'h0040,
        ST_DIV     = 16'h0080,
        ST_MUL_L   = 16'h0100,
        ST_MUL_D   = 16'h0200,
        ST_I_END   = 16'h0400,
        ST_B_READ  = 16'h0800,
        ST_B_EVAL  = 16'h1000,
        ST_B_M2    = 16'h2000,
        ST_B_CMP   = 16'h4000,
        ST_DONE    = 16'h8000
    } state_t;

endpackage

[hdl/ati_ram.sv]
// ----------------------------------------------------------------------------
// ati_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module ati_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/airfoil_table_interpolator_core.sv]
// ----------------------------------------------------------------------------
// airfoil_table_interpolator_core
// angle/lift/drag table with load, interpolate and best-ratio requests
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_entries_in_use
//  s       | in        | s_valid/s_ready    | func, entry index/angle/lift/drag, query
//  m       | out       | m_valid/m_ready    | status, lift_out, drag_out, best_angle
//
//  one request at a time through a small sequencer around one table ram
//  (one read per cycle, registered read data), a 17x17 multiplier and a
//  restoring divider that yields one quotient bit per cycle
//  load: written in the accepting cycle; interpolate: time set by the search
//  probes through the single ram read port and the 16 divider steps, which a
//  query out of range or on the last angle skips; best angle: each entry in use
//  is read and evaluated, and one with nonzero lift is compared with the best
//  reset: synchronous, active low, clears sequencer, output valid and the
//  register (to 3); the table is not cleared
//  the result sits in an output register, so the next request is taken while
//  it waits; the sequencer only stalls in its final state if that is still full
`include "airfoil_table_interpolator_core_assert.svh"

module airfoil_table_interpolator_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_entries_in_use,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [5:0]         s_entry_index,
    input  logic [15:0]        s_entry_angle,
    input  logic signed [15:0] s_entry_lift,
    input  logic signed [15:0] s_entry_drag,
    input  logic [15:0]        s_query_angle,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [15:0] m_lift_out,
    output logic signed [15:0] m_drag_out,
    output logic [15:0]        m_best_angle
);

    import ati_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    // sequencer and register
    state_t state_reg, state_next;
    logic [6:0] cfg_reg;

    // request context
    logic [1:0]  func_reg;
    logic [15:0] q_reg;

    // search and scan indices
    logic [AW-1:0] lo_reg, hi_reg, mid_reg, idx_reg;
    logic [AW-1:0] rd_addr_next;

    // segment end points
    logic [15:0]        a_lo_reg, a_hi_reg;
    logic signed [15:0] lift_lo_reg, drag_lo_reg, lift_hi_reg, drag_hi_reg;

    // divider
    logic [15:0] rem_reg, den_reg, quo_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] rem_shl;

    // shared multiplier
    mul_op_t mul_a, mul_b;
    prod_t   prod_reg, keep_reg;

    // best-ratio scan
    logic [15:0]        cur_angle_reg, best_angle_reg;
    logic signed [15:0] cur_lift_reg, cur_drag_reg, best_lift_reg, best_drag_reg;
    logic               found_reg;
    mul_op_t            cur_nd, cur_al, best_nd, best_al;

    // results
    logic [1:0]         res_status_reg;
    logic signed [15:0] res_lift_reg, res_drag_reg;

    // output register
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic signed [15:0] m_lift_reg, m_drag_reg;
    logic [15:0]        m_best_reg;

    // table ram
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [15:0]        rd_angle;
    logic signed [15:0] rd_lift, rd_drag;

    // entries in use, clamped into 3 .. TABLE_DEPTH
    logic [NW-1:0] n_cur;
    logic [AW-1:0] last_idx;
    logic          load_ok, s_accept, out_free;

    always_comb begin
        if (int'(cfg_reg) < MIN_ENTRIES) begin
            n_cur = NW'(MIN_ENTRIES);
        end else if (int'(cfg_reg) > TABLE_DEPTH) begin
            n_cur = NW'(TABLE_DEPTH);
        end else begin
            n_cur = NW'(cfg_reg);
        end
    end

    assign last_idx  = AW'(n_cur - NW'(1));
    assign load_ok   = int'(s_entry_index) < int'(n_cur);
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // loads write straight from the request in the accepting cycle
    assign ram_we    = s_accept && (s_func == FUNC_LOAD) && load_ok;
    assign ram_waddr = AW'(s_entry_index);

    assign rd_angle = ram_rdata[47:32];
    assign rd_lift  = ram_rdata[31:16];
    assign rd_drag  = ram_rdata[15:0];

    ati_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data ({s_entry_angle, s_entry_lift, s_entry_drag}),
        .rd_addr (rd_addr_next),
        .rd_data (ram_rdata)
    );

    // sign-normalised ratio operands: d/l compared as d*|l'| against d'*|l|
    assign cur_nd  = cur_lift_reg[15]  ? -{cur_drag_reg[15], cur_drag_reg}
                                       :  {cur_drag_reg[15], cur_drag_reg};
    assign cur_al  = cur_lift_reg[15]  ? -{cur_lift_reg[15], cur_lift_reg}
                                       :  {cur_lift_reg[15], cur_lift_reg};
    assign best_nd = best_lift_reg[15] ? -{best_drag_reg[15], best_drag_reg}
                                       :  {best_drag_reg[15], best_drag_reg};
    assign best_al = best_lift_reg[15] ? -{best_lift_reg[15], best_lift_reg}
                                       :  {best_lift_reg[15], best_lift_reg};

    // operand select for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_L: begin
                mul_a = {1'b0, quo_reg};
                mul_b = {lift_hi_reg[15], lift_hi_reg} - {lift_lo_reg[15], lift_lo_reg};
            end
            ST_MUL_D: begin
                mul_a = {1'b0, quo_reg};
                mul_b = {drag_hi_reg[15], drag_hi_reg} - {drag_lo_reg[15], drag_lo_reg};
            end
            ST_B_EVAL: begin
                mul_a = cur_nd;
                mul_b = best_al;
            end
            ST_B_M2: begin
                mul_a = best_nd;
                mul_b = cur_al;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rem_shl = {rem_reg, 1'b0};

    // next state and ram read address
    always_comb begin
        state_next   = state_reg;
        rd_addr_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_func)
                        FUNC_INTERP: state_next = ST_I_FIRST;
                        FUNC_BEST:   state_next = ST_B_READ;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_I_FIRST: begin
                rd_addr_next = last_idx;
                state_next   = ST_I_LAST;
            end
            ST_I_LAST: begin
                if ((q_reg < a_lo_reg) || (q_reg >= rd_angle)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_I_SRCH;
                end
            end
            ST_I_SRCH: begin
                if ((hi_reg - lo_reg) > AW'(1)) begin
                    rd_addr_next = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
                    state_next   = ST_I_PROBE;
                end else begin
                    rd_addr_next = lo_reg;
                    state_next   = ST_I_RLO;
                end
            end
            ST_I_PROBE: state_next = ST_I_SRCH;
            ST_I_RLO: begin
                rd_addr_next = hi_reg;
                state_next   = ST_I_RHI;
            end
            ST_I_RHI: begin
                state_next = (a_hi_reg > a_lo_reg) ? ST_DIV : ST_MUL_L;
            end
            ST_DIV: begin
                if (cnt_reg == 5'd1) begin
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_I_END;
            ST_I_END: state_next = ST_DONE;
            ST_B_READ: state_next = ST_B_EVAL;
            ST_B_EVAL: begin
                if ((cur_lift_reg == '0) || !found_reg) begin
                    if (idx_reg == last_idx) begin
                        state_next = ST_DONE;
                    end else begin
                        rd_addr_next = idx_reg + AW'(1);
                        state_next   = ST_B_READ;
                    end
                end else begin
                    state_next = ST_B_M2;
                end
            end
            ST_B_M2: state_next = ST_B_CMP;
            ST_B_CMP: begin
                if (idx_reg == last_idx) begin
                    state_next = ST_DONE;
                end else begin
                    rd_addr_next = idx_reg + AW'(1);
                    state_next   = ST_B_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_entries_in_use;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    func_reg       <= s_func;
                    q_reg          <= s_query_angle;
                    res_lift_reg   <= '0;
                    res_drag_reg   <= '0;
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    res_status_reg <= ((s_func == FUNC_LOAD) && !load_ok) ? STATUS_INDEX
                                                                          : STATUS_OK;
                end
            end
            ST_I_FIRST: a_lo_reg <= rd_angle;
            ST_I_LAST: begin
                a_hi_reg <= rd_angle;
                lo_reg   <= '0;
                hi_reg   <= last_idx;
                if ((q_reg < a_lo_reg) || (q_reg > rd_angle)) begin
                    res_status_reg <= STATUS_RANGE;
                end else if (q_reg == rd_angle) begin
                    // query on the last angle: last entry as it stands
                    res_lift_reg <= rd_lift;
                    res_drag_reg <= rd_drag;
                end
            end
            ST_I_SRCH: mid_reg <= AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
            ST_I_PROBE: begin
                if (rd_angle <= q_reg) begin
                    lo_reg   <= mid_reg;
                    a_lo_reg <= rd_angle;
                end else begin
                    hi_reg   <= mid_reg;
                    a_hi_reg <= rd_angle;
                end
            end
            ST_I_RLO: begin
                lift_lo_reg <= rd_lift;
                drag_lo_reg <= rd_drag;
            end
            ST_I_RHI: begin
                lift_hi_reg <= rd_lift;
                drag_hi_reg <= rd_drag;
                rem_reg     <= q_reg - a_lo_reg;
                den_reg     <= a_hi_reg - a_lo_reg;
                quo_reg     <= '0;
                cnt_reg     <= DIV_STEPS;
            end
            ST_DIV: begin
                // remainder stays below the divisor, so 17 bits suffice
                if (rem_shl >= {1'b0, den_reg}) begin
                    rem_reg <= 16'(rem_shl - {1'b0, den_reg});
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end else begin
                    rem_reg <= rem_shl[15:0];
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_MUL_L: prod_reg <= mul_a * mul_b;
            ST_MUL_D: begin
                // arithmetic shift by 16 rounds toward minus infinity
                res_lift_reg <= lift_lo_reg + prod_reg[31:16];
                prod_reg     <= mul_a * mul_b;
            end
            ST_I_END: res_drag_reg <= drag_lo_reg + prod_reg[31:16];
            ST_B_READ: begin
                cur_angle_reg <= rd_angle;
                cur_lift_reg  <= rd_lift;
                cur_drag_reg  <= rd_drag;
                // no usable lift anywhere gives the first angle
                if (idx_reg == '0) begin
                    best_angle_reg <= rd_angle;
                end
            end
            ST_B_EVAL: begin
                if ((cur_lift_reg != '0) && !found_reg) begin
                    best_angle_reg <= cur_angle_reg;
                    best_lift_reg  <= cur_lift_reg;
                    best_drag_reg  <= cur_drag_reg;
                    found_reg      <= 1'b1;
                end
                if ((cur_lift_reg == '0) || !found_reg) begin
                    idx_reg <= idx_reg + AW'(1);
                end
                prod_reg <= mul_a * mul_b;
            end
            ST_B_M2: begin
                keep_reg <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            ST_B_CMP: begin
                // strict compare keeps the earlier entry on a tie
                if (keep_reg < prod_reg) begin
                    best_angle_reg <= cur_angle_reg;
                    best_lift_reg  <= cur_lift_reg;
                    best_drag_reg  <= cur_drag_reg;
                end
                idx_reg <= idx_reg + AW'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_lift_reg   <= res_lift_reg;
                    m_drag_reg   <= res_drag_reg;
                    m_best_reg   <= (func_reg == FUNC_BEST) ? best_angle_reg : 16'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_lift_out   = m_lift_reg;
    assign m_drag_out   = m_drag_reg;
    assign m_best_angle = m_best_reg;

    // checks
    `ATI_ASSERT_NOW(a_div_count, aclk, aresetn, (state_reg == ST_DIV), (cnt_reg != 5'd0), "divider ran past its last step")
    `ATI_ASSERT_NOW(a_probe_order, aclk, aresetn, (state_reg == ST_I_PROBE), (lo_reg < hi_reg), "search bounds crossed")
    `ATI_ASSERT_NOW(a_scan_bound, aclk, aresetn, (state_reg == ST_B_READ), (idx_reg <= last_idx), "scan index beyond entries in use")
    `ATI_ASSERT_NEXT(a_result_out, aclk, aresetn, ((state_reg == ST_DONE) && out_free), (m_valid && s_ready), "finished request not presented")

endmodule
